FILE: rtl/psc_pkg.sv
// ----------------------------------------------------------------------------
// Polybius square cipher package
// Shared constants, queue entry and status types, and the character helpers
// used by the front classifier and the back execution unit.
// ----------------------------------------------------------------------------
package psc_pkg;

  // Square geometry and field widths.
  localparam int GRID_SIDE  = 6;
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int SYM_W      = $clog2(CELL_COUNT);
  localparam int DIG_W      = $clog2(GRID_SIDE);
  localparam int CHAR_W     = 8;
  localparam int CMD_W      = 2;
  localparam int LETTERS    = 26;

  // Command codes on the input channel.
  localparam logic [CMD_W-1:0] CMD_KEY     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_END_KEY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MSG     = 2'd2;

  // ASCII codes.
  localparam logic [CHAR_W-1:0] ASCII_A     = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_Z     = 8'h5A;
  localparam logic [CHAR_W-1:0] ASCII_0     = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_9     = 8'h39;
  localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] ASCII_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] ASCII_CR    = 8'h0D;

  // Operations handed from the front to the back.
  typedef enum logic [2:0] {
    OP_KEY,
    OP_FILL,
    OP_BLANK,
    OP_ENC,
    OP_DEC
  } op_t;

  // One queue entry. For OP_KEY and OP_ENC arg is the symbol, for OP_DEC the
  // low bits hold the digit, and for OP_BLANK bit 0 asks to drop a pending digit.
  typedef struct packed {
    op_t              op;
    logic [SYM_W-1:0] arg;
  } qent_t;

  // Status of the back unit, watched at the top level.
  typedef struct packed {
    logic fill_busy;
    logic pend_valid;
  } back_stat_t;

  // True for A-Z and 0-9.
  function automatic logic is_symbol(input logic [CHAR_W-1:0] ch);
    return ((ch >= ASCII_A) && (ch <= ASCII_Z)) || ((ch >= ASCII_0) && (ch <= ASCII_9));
  endfunction

  // Symbol index of a byte that is_symbol accepts.
  function automatic logic [SYM_W-1:0] symbol_of(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] t;
    if (ch >= ASCII_A) begin
      t = ch - ASCII_A;
    end else begin
      t = ch - ASCII_0 + CHAR_W'(LETTERS);
    end
    return t[SYM_W-1:0];
  endfunction

  // Grid character of a symbol index.
  function automatic logic [CHAR_W-1:0] char_of(input logic [SYM_W-1:0] sym);
    logic [CHAR_W-1:0] wide;
    wide = {{(CHAR_W-SYM_W){1'b0}}, sym};
    if (wide < CHAR_W'(LETTERS)) begin
      return ASCII_A + wide;
    end
    return ASCII_0 + wide - CHAR_W'(LETTERS);
  endfunction

  // Space, tab, newline, vertical tab, form feed and carriage return.
  function automatic logic is_blank(input logic [CHAR_W-1:0] ch);
    return (ch == ASCII_SPACE) || ((ch >= ASCII_TAB) && (ch <= ASCII_CR));
  endfunction

  // Row of a cell index, found by comparing against row starts.
  function automatic logic [DIG_W-1:0] row_of(input logic [SYM_W-1:0] pos);
    logic [DIG_W-1:0] r;
    r = '0;
    for (int k = 1; k < GRID_SIDE; k++) begin
      if (pos >= SYM_W'(k * GRID_SIDE)) r = DIG_W'(k);
    end
    return r;
  endfunction

  // Column of a cell index.
  function automatic logic [DIG_W-1:0] col_of(input logic [SYM_W-1:0] pos);
    logic [SYM_W-1:0] base;
    logic [SYM_W-1:0] diff;
    base = SYM_W'(row_of(pos) * GRID_SIDE);
    diff = pos - base;
    return diff[DIG_W-1:0];
  endfunction

  // Cell index of a row and column.
  function automatic logic [SYM_W-1:0] cell_of(input logic [DIG_W-1:0] row,
                                               input logic [DIG_W-1:0] col);
    return SYM_W'(row * GRID_SIDE) + {{(SYM_W-DIG_W){1'b0}}, col};
  endfunction

endpackage

FILE: rtl/psc_front.sv
// ----------------------------------------------------------------------------
// Polybius square front classifier
// Accepts input requests, sorts them into key, fill, blank, encrypt and
// decrypt operations and pushes them to the queue. Requests whose command or
// character is of no use are accepted and dropped here.
// ----------------------------------------------------------------------------
module psc_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [psc_pkg::CMD_W-1:0]     in_command,
  input  logic [psc_pkg::CHAR_W-1:0]    in_char,
  input  logic                          encrypt_mode,
  input  logic                          q_full,
  output logic                          q_push,
  output psc_pkg::qent_t                q_data
);

  logic keep;
  logic sym_ok;
  logic dig_ok;

  // A request is taken whenever the queue has room.
  assign in_ready = !q_full;

  assign sym_ok = psc_pkg::is_symbol(in_char);
  assign dig_ok = (in_char >= psc_pkg::ASCII_0) &&
                  (in_char <  psc_pkg::ASCII_0 + psc_pkg::CHAR_W'(psc_pkg::GRID_SIDE));

  // Classify the request.
  always_comb begin
    keep        = 1'b0;
    q_data.op   = psc_pkg::OP_KEY;
    q_data.arg  = psc_pkg::symbol_of(in_char);
    case (in_command)
      psc_pkg::CMD_KEY: begin
        keep = sym_ok;
      end
      psc_pkg::CMD_END_KEY: begin
        keep      = 1'b1;
        q_data.op = psc_pkg::OP_FILL;
      end
      psc_pkg::CMD_MSG: begin
        if (psc_pkg::is_blank(in_char)) begin
          // Bit 0 tells the back to drop a pending digit in decrypt mode.
          keep       = 1'b1;
          q_data.op  = psc_pkg::OP_BLANK;
          q_data.arg = {{(psc_pkg::SYM_W-1){1'b0}}, !encrypt_mode};
        end else if (encrypt_mode) begin
          keep      = sym_ok;
          q_data.op = psc_pkg::OP_ENC;
        end else begin
          keep       = dig_ok;
          q_data.op  = psc_pkg::OP_DEC;
          q_data.arg = {{(psc_pkg::SYM_W-psc_pkg::DIG_W){1'b0}},
                        in_char[psc_pkg::DIG_W-1:0]};
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = in_valid && in_ready && keep;

endmodule

FILE: rtl/psc_queue.sv
// ----------------------------------------------------------------------------
// Polybius square operation queue
// Two-entry first-in first-out buffer between the front classifier and the
// back execution unit.
// ----------------------------------------------------------------------------
module psc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  psc_pkg::qent_t  push_data,
  input  logic            pop,
  output psc_pkg::qent_t  head,
  output logic            empty,
  output logic            full
);

  psc_pkg::qent_t ent_r [2];
  logic           wr_ptr_r;
  logic           wr_ptr_nxt;
  logic           rd_ptr_r;
  logic           rd_ptr_nxt;
  logic [1:0]     count_r;
  logic [1:0]     count_nxt;

  assign empty = (count_r == 2'd0);
  assign full  = (count_r == 2'd2);
  assign head  = ent_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/psc_back.sv
// ----------------------------------------------------------------------------
// Polybius square back execution unit
// Owns the square and symbol position memories, the used map, the fill
// counter and the pending decrypt digit, and drives the result register.
// ----------------------------------------------------------------------------
module psc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  psc_pkg::qent_t                head,
  input  logic                          q_empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [psc_pkg::CHAR_W-1:0]    out_char,
  output logic                          out_last,
  output psc_pkg::back_stat_t           stat
);

  localparam int SW = psc_pkg::SYM_W;
  localparam int DW = psc_pkg::DIG_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_ENC_HI,
    ST_ENC_LO,
    ST_DEC
  } state_t;

  state_t                         state_r, state_nxt;
  logic [psc_pkg::CELL_COUNT-1:0] used_r, used_nxt;
  logic [SW:0]                    fill_r, fill_nxt;
  logic [SW-1:0]                  cnt_r, cnt_nxt;
  logic [DW-1:0]                  pend_digit_r, pend_digit_nxt;
  logic                           pend_valid_r, pend_valid_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [psc_pkg::CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                           out_last_r, out_last_nxt;

  // Memories: cell to symbol and symbol to cell.
  logic [SW-1:0] grid_mem [psc_pkg::CELL_COUNT];
  logic [SW-1:0] pos_mem  [psc_pkg::CELL_COUNT];
  logic [SW-1:0] grid_rd_r;
  logic [SW-1:0] pos_rd_r;
  logic          grid_rd_en;
  logic [SW-1:0] grid_rd_addr;
  logic          pos_rd_en;
  logic [SW-1:0] pos_rd_addr;

  logic          place_try;
  logic [SW-1:0] place_sym;
  logic          place_we;
  logic          slot_free;
  logic          load;
  logic [psc_pkg::CHAR_W-1:0] load_char;
  logic          load_last;

  assign slot_free = !out_valid_r || out_ready;

  // Placement of a symbol in the next free cell.
  assign place_we = place_try && !used_r[place_sym] &&
                    (fill_r != (SW+1)'(psc_pkg::CELL_COUNT));

  // Operation sequencing.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pend_digit_nxt = pend_digit_r;
    pend_valid_nxt = pend_valid_r;
    pop            = 1'b0;
    place_try      = 1'b0;
    place_sym      = head.arg;
    grid_rd_en     = 1'b0;
    grid_rd_addr   = psc_pkg::cell_of(pend_digit_r, head.arg[DW-1:0]);
    pos_rd_en      = 1'b0;
    pos_rd_addr    = head.arg;
    load           = 1'b0;
    load_char      = psc_pkg::ASCII_SPACE;
    load_last      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          case (head.op)
            psc_pkg::OP_KEY: begin
              pop       = 1'b1;
              place_try = 1'b1;
            end
            psc_pkg::OP_FILL: begin
              pop       = 1'b1;
              cnt_nxt   = '0;
              state_nxt = ST_FILL;
            end
            psc_pkg::OP_BLANK: begin
              if (slot_free) begin
                pop  = 1'b1;
                load = 1'b1;
                if (head.arg[0]) begin
                  pend_valid_nxt = 1'b0;
                  pend_digit_nxt = '0;
                end
              end
            end
            psc_pkg::OP_ENC: begin
              pop       = 1'b1;
              pos_rd_en = 1'b1;
              state_nxt = ST_ENC_HI;
            end
            psc_pkg::OP_DEC: begin
              pop = 1'b1;
              if (!pend_valid_r) begin
                pend_digit_nxt = head.arg[DW-1:0];
                pend_valid_nxt = 1'b1;
              end else begin
                grid_rd_en     = 1'b1;
                pend_valid_nxt = 1'b0;
                pend_digit_nxt = '0;
                state_nxt      = ST_DEC;
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      ST_FILL: begin
        // One symbol of the alphabet is checked each cycle.
        place_try = 1'b1;
        place_sym = cnt_r;
        if (cnt_r == SW'(psc_pkg::CELL_COUNT - 1)) begin
          pend_valid_nxt = 1'b0;
          pend_digit_nxt = '0;
          state_nxt      = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + SW'(1);
        end
      end
      ST_ENC_HI: begin
        if (slot_free) begin
          load      = 1'b1;
          load_char = psc_pkg::ASCII_0 + {{(psc_pkg::CHAR_W-DW){1'b0}},
                                          psc_pkg::row_of(pos_rd_r)};
          load_last = 1'b0;
          state_nxt = ST_ENC_LO;
        end
      end
      ST_ENC_LO: begin
        if (slot_free) begin
          load      = 1'b1;
          load_char = psc_pkg::ASCII_0 + {{(psc_pkg::CHAR_W-DW){1'b0}},
                                          psc_pkg::col_of(pos_rd_r)};
          state_nxt = ST_IDLE;
        end
      end
      ST_DEC: begin
        if (slot_free) begin
          load      = 1'b1;
          load_char = psc_pkg::char_of(grid_rd_r);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Used map and fill count; the end of a fill starts a fresh square.
  always_comb begin
    used_nxt = used_r;
    fill_nxt = fill_r;
    if (place_we) begin
      used_nxt[place_sym] = 1'b1;
      fill_nxt            = fill_r + (SW+1)'(1);
    end
    if ((state_r == ST_FILL) && (cnt_r == SW'(psc_pkg::CELL_COUNT - 1))) begin
      used_nxt = '0;
      fill_nxt = '0;
    end
  end

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = load_char;
      out_last_nxt  = load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      used_r       <= '0;
      fill_r       <= '0;
      cnt_r        <= '0;
      pend_digit_r <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      fill_r       <= fill_nxt;
      cnt_r        <= cnt_nxt;
      pend_digit_r <= pend_digit_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Square and position memories with registered reads.
  always_ff @(posedge clk) begin
    if (place_we) begin
      grid_mem[fill_r[SW-1:0]] <= place_sym;
      pos_mem[place_sym]       <= fill_r[SW-1:0];
    end
    if (grid_rd_en) begin
      grid_rd_r <= grid_mem[grid_rd_addr];
    end
    if (pos_rd_en) begin
      pos_rd_r <= pos_mem[pos_rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_last        = out_last_r;
  assign stat.fill_busy  = (state_r == ST_FILL);
  assign stat.pend_valid = pend_valid_r;

endmodule

FILE: rtl/polybius_square_cipher.sv
// ----------------------------------------------------------------------------
// Keyed 6x6 Polybius square cipher
// Builds a keyed square from streamed key characters, completes it on end of
// key, then encrypts characters to row/column digits or decrypts digit pairs.
// ----------------------------------------------------------------------------
// A request passes through the queue and the back unit into the result
// register; encrypt and decrypt results also pass a registered memory read.
// The execution unit takes one queue entry at a time and finishes it before
// popping the next; an end of key runs a fill that walks the 36 symbols one
// per cycle.
// Reset clears the used map, fill count, pending digit, queue and result;
// encrypt_mode resets to 1. The square memories hold no reset value.
module polybius_square_cipher (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [psc_pkg::CMD_W-1:0]     in_command,
  input  logic [psc_pkg::CHAR_W-1:0]    in_char,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [psc_pkg::CHAR_W-1:0]    out_char,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_encrypt_mode
);

  logic                mode_r;
  logic                q_push;
  psc_pkg::qent_t      q_data;
  psc_pkg::qent_t      q_head;
  logic                q_pop;
  logic                q_empty;
  logic                q_full;
  psc_pkg::back_stat_t stat;

  // Mode register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_encrypt_mode;
    end
  end

  psc_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_char      (in_char),
    .encrypt_mode (mode_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_data)
  );

  psc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  psc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last),
    .stat      (stat)
  );

  // No result is produced while the fill sweep runs.
  a_no_result_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(stat.fill_busy))
    else $error("result loaded during grid fill");

  // The second digit of a pair follows the first without a gap.
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("second digit missing after first digit");

  // Finishing the fill leaves no pending decrypt digit.
  a_fill_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(stat.fill_busy) |-> !stat.pend_valid)
    else $error("pending digit survived end of key");

  // The queue is never popped while empty.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polybius square cipher testbench
// Drives key, end-of-key and message requests through the valid/ready input
// channel with bursty pacing, stalls the result channel on a changing pattern
// and checks every result against a cycle-free model of the keyed square.
// Switches between encrypt and decrypt modes through the configuration port
// while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [psc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int SETTLE_CYCLES  = 100;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic ENC = 1'b1;
  localparam logic DEC = 1'b0;
  localparam logic TYPED = 1'b1;
  localparam logic MODEL = 1'b0;

  // One result character as it should appear on the output channel.
  typedef struct packed {
    logic [psc_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } cipher_out_t;

  // One directed request: mode to run in, payload and, where it is obvious,
  // the results typed in by hand.
  typedef struct packed {
    logic                       enc;
    logic [psc_pkg::CMD_W-1:0]  cmd;
    logic [psc_pkg::CHAR_W-1:0] ch;
    logic                       typed;
    logic [1:0]                 n;
    logic [psc_pkg::CHAR_W-1:0] e0;
    logic [psc_pkg::CHAR_W-1:0] e1;
  } probe_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_style_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [psc_pkg::CMD_W-1:0] in_command = psc_pkg::CMD_KEY;
  logic [psc_pkg::CHAR_W-1:0] in_char = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [psc_pkg::CHAR_W-1:0] out_char;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_encrypt_mode = 1'b1;

  // Square model state.
  logic [psc_pkg::SYM_W-1:0] slot_sym [psc_pkg::CELL_COUNT];
  logic [psc_pkg::SYM_W-1:0] sym_slot [psc_pkg::CELL_COUNT];
  logic [psc_pkg::CELL_COUNT-1:0] taken = '0;
  logic [psc_pkg::SYM_W-1:0] next_slot = '0;
  logic [2:0] held_row = '0;
  logic held = 1'b0;
  logic enc_mode = 1'b1;

  cipher_out_t expected_chars [$];

  int fail_count = 0;
  int requests_accepted = 0;
  int results_checked = 0;
  int useful_items = 0;
  int squares_built = 0;
  int full_keys = 0;
  int mode_writes [2] = '{0, 0};
  int burst_left = 0;
  int quiet_cycles = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  logic [7:0] rx_tick = '0;
  rx_style_t rx_style = RX_OPEN;

  probe_t probes [27] = '{
    '{ENC, psc_pkg::CMD_END_KEY, 8'h00, TYPED, 2'd0, 8'h00, 8'h00},
    '{ENC, psc_pkg::CMD_MSG, "A", TYPED, 2'd2, "0", "0"},
    '{ENC, psc_pkg::CMD_MSG, "9", TYPED, 2'd2, "5", "5"},
    '{ENC, psc_pkg::CMD_MSG, psc_pkg::ASCII_SPACE, TYPED, 2'd1, psc_pkg::ASCII_SPACE, 8'h00},
    '{ENC, psc_pkg::CMD_MSG, psc_pkg::ASCII_TAB, TYPED, 2'd1, psc_pkg::ASCII_SPACE, 8'h00},
    '{ENC, psc_pkg::CMD_MSG, psc_pkg::ASCII_CR, TYPED, 2'd1, psc_pkg::ASCII_SPACE, 8'h00},
    '{ENC, psc_pkg::CMD_MSG, "a", TYPED, 2'd0, 8'h00, 8'h00},
    '{ENC, psc_pkg::CMD_MSG, 8'hFF, TYPED, 2'd0, 8'h00, 8'h00},
    '{ENC, CMD_UNUSED, 8'hFF, TYPED, 2'd0, 8'h00, 8'h00},
    '{ENC, psc_pkg::CMD_KEY, "9", MODEL, 2'd0, 8'h00, 8'h00},
    '{ENC, psc_pkg::CMD_KEY, "9", MODEL, 2'd0, 8'h00, 8'h00},
    '{ENC, psc_pkg::CMD_KEY, "#", MODEL, 2'd0, 8'h00, 8'h00},
    '{ENC, psc_pkg::CMD_END_KEY, 8'h00, MODEL, 2'd0, 8'h00, 8'h00},
    '{ENC, psc_pkg::CMD_MSG, "9", MODEL, 2'd0, 8'h00, 8'h00},
    '{DEC, psc_pkg::CMD_MSG, "0", MODEL, 2'd0, 8'h00, 8'h00},
    '{DEC, psc_pkg::CMD_MSG, "x", MODEL, 2'd0, 8'h00, 8'h00},
    '{DEC, psc_pkg::CMD_MSG, "0", MODEL, 2'd0, 8'h00, 8'h00},
    '{DEC, psc_pkg::CMD_MSG, "5", MODEL, 2'd0, 8'h00, 8'h00},
    '{DEC, psc_pkg::CMD_MSG, 8'h0B, MODEL, 2'd0, 8'h00, 8'h00},
    '{DEC, psc_pkg::CMD_MSG, "6", MODEL, 2'd0, 8'h00, 8'h00},
    '{DEC, psc_pkg::CMD_MSG, "5", MODEL, 2'd0, 8'h00, 8'h00},
    '{ENC, psc_pkg::CMD_MSG, "B", MODEL, 2'd0, 8'h00, 8'h00},
    '{DEC, psc_pkg::CMD_MSG, "5", MODEL, 2'd0, 8'h00, 8'h00},
    '{DEC, psc_pkg::CMD_MSG, "2", MODEL, 2'd0, 8'h00, 8'h00},
    '{DEC, psc_pkg::CMD_END_KEY, 8'h00, MODEL, 2'd0, 8'h00, 8'h00},
    '{DEC, psc_pkg::CMD_MSG, "3", MODEL, 2'd0, 8'h00, 8'h00},
    '{DEC, psc_pkg::CMD_MSG, "1", MODEL, 2'd0, 8'h00, 8'h00}
  };

  polybius_square_cipher DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_char          (in_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char         (out_char),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_encrypt_mode (cfg_encrypt_mode)
  );

  always #5 clk = ~clk;

  // Alphabet position of a byte, or -1 when it is not A-Z or 0-9.
  function automatic int alpha_index(input logic [psc_pkg::CHAR_W-1:0] ch);
    if (ch >= psc_pkg::ASCII_A && ch <= psc_pkg::ASCII_Z) return int'(ch - psc_pkg::ASCII_A);
    if (ch >= psc_pkg::ASCII_0 && ch <= psc_pkg::ASCII_9) begin
      return psc_pkg::LETTERS + int'(ch - psc_pkg::ASCII_0);
    end
    return -1;
  endfunction

  function automatic logic [psc_pkg::CHAR_W-1:0] alpha_char(input logic [psc_pkg::SYM_W-1:0] s);
    int v = int'(s);
    if (v < psc_pkg::LETTERS) return psc_pkg::ASCII_A + psc_pkg::CHAR_W'(v);
    return psc_pkg::ASCII_0 + psc_pkg::CHAR_W'(v - psc_pkg::LETTERS);
  endfunction

  function automatic logic blank_char(input logic [psc_pkg::CHAR_W-1:0] ch);
    return ch == psc_pkg::ASCII_SPACE ||
           (ch >= psc_pkg::ASCII_TAB && ch <= psc_pkg::ASCII_CR);
  endfunction

  // Put a symbol into the next free slot of the square, if there is one.
  function automatic void take_symbol(input logic [psc_pkg::SYM_W-1:0] s);
    if (int'(next_slot) < psc_pkg::CELL_COUNT) begin
      slot_sym[next_slot] = s;
      sym_slot[s] = next_slot;
      taken[s] = 1'b1;
      next_slot = next_slot + 1'b1;
    end
  endfunction

  // Advance the square model by one request and return the characters it
  // should produce. touched is low when the block simply drops the request.
  task automatic cipher_model(input logic [psc_pkg::CMD_W-1:0] cmd,
                              input logic [psc_pkg::CHAR_W-1:0] ch,
                              output logic [1:0] n,
                              output logic [psc_pkg::CHAR_W-1:0] r0,
                              output logic [psc_pkg::CHAR_W-1:0] r1,
                              output bit touched);
    int idx;
    int s;
    logic [psc_pkg::SYM_W-1:0] pos;
    logic [2:0] digit;
    n = 2'd0;
    r0 = '0;
    r1 = '0;
    touched = 1'b0;
    idx = alpha_index(ch);
    case (cmd)
      psc_pkg::CMD_KEY: begin
        if (idx >= 0 && !taken[idx] && int'(next_slot) < psc_pkg::CELL_COUNT) begin
          take_symbol(psc_pkg::SYM_W'(idx));
          touched = 1'b1;
        end
      end
      psc_pkg::CMD_END_KEY: begin
        if (int'(next_slot) == psc_pkg::CELL_COUNT) full_keys++;
        for (s = 0; s < psc_pkg::CELL_COUNT; s++) begin
          if (!taken[s]) take_symbol(psc_pkg::SYM_W'(s));
        end
        taken = '0;
        next_slot = '0;
        held = 1'b0;
        held_row = '0;
        squares_built++;
        touched = 1'b1;
      end
      psc_pkg::CMD_MSG: begin
        if (blank_char(ch)) begin
          // A blank always echoes a space; in decrypt mode it also drops a half pair.
          if (!enc_mode) begin
            held = 1'b0;
            held_row = '0;
          end
          r0 = psc_pkg::ASCII_SPACE;
          n = 2'd1;
          touched = 1'b1;
        end else if (enc_mode) begin
          if (idx >= 0) begin
            pos = sym_slot[idx];
            r0 = psc_pkg::ASCII_0 + psc_pkg::CHAR_W'(int'(pos) / psc_pkg::GRID_SIDE);
            r1 = psc_pkg::ASCII_0 + psc_pkg::CHAR_W'(int'(pos) % psc_pkg::GRID_SIDE);
            n = 2'd2;
            touched = 1'b1;
          end
        end else if (ch >= psc_pkg::ASCII_0 &&
                     ch < psc_pkg::ASCII_0 + psc_pkg::CHAR_W'(psc_pkg::GRID_SIDE)) begin
          // Decrypt: the first digit waits for its partner.
          digit = 3'(ch - psc_pkg::ASCII_0);
          if (!held) begin
            held_row = digit;
            held = 1'b1;
          end else begin
            r0 = alpha_char(slot_sym[int'(held_row) * psc_pkg::GRID_SIDE + int'(digit)]);
            n = 2'd1;
            held = 1'b0;
            held_row = '0;
          end
          touched = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endtask

  // Offer one request in the current burst, wait for it to be taken and
  // record what it should produce.
  task automatic offer(input logic [psc_pkg::CMD_W-1:0] cmd,
                       input logic [psc_pkg::CHAR_W-1:0] ch,
                       input logic typed, input logic [1:0] tn,
                       input logic [psc_pkg::CHAR_W-1:0] t0,
                       input logic [psc_pkg::CHAR_W-1:0] t1);
    logic [1:0] n;
    logic [psc_pkg::CHAR_W-1:0] r0;
    logic [psc_pkg::CHAR_W-1:0] r1;
    bit touched;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_char <= ch;
    do @(posedge clk); while (!in_ready);
    requests_accepted++;
    cipher_model(cmd, ch, n, r0, r1, touched);
    if (typed) begin
      n = tn;
      r0 = t0;
      r1 = t1;
    end
    if (touched) useful_items++;
    if (n == 2'd2) begin
      expected_chars.push_back('{r0, 1'b0});
      expected_chars.push_back('{r1, 1'b1});
    end else if (n == 2'd1) begin
      expected_chars.push_back('{r0, 1'b1});
    end
  endtask

  task automatic push_item(input logic [psc_pkg::CMD_W-1:0] cmd,
                           input logic [psc_pkg::CHAR_W-1:0] ch);
    offer(cmd, ch, MODEL, 2'd0, '0, '0);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  // Mode writes happen only with the block idle, so let any queued requests
  // that give no result (a fill, for one) finish first.
  task automatic write_mode(input logic m);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_encrypt_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    enc_mode = m;
    mode_writes[m]++;
  endtask

  function automatic logic [psc_pkg::CHAR_W-1:0] rand_symbol_char();
    return alpha_char(psc_pkg::SYM_W'($urandom_range(0, psc_pkg::CELL_COUNT - 1)));
  endfunction

  function automatic logic [psc_pkg::CHAR_W-1:0] rand_blank();
    int k = $urandom_range(0, 5);
    return (k == 0) ? psc_pkg::ASCII_SPACE : psc_pkg::ASCII_TAB + psc_pkg::CHAR_W'(k - 1);
  endfunction

  // A key: usually a short run of symbols with some junk mixed in, now and
  // then every symbol in shuffled order so the square fills from the key alone.
  task automatic build_key();
    int perm [psc_pkg::CELL_COUNT];
    int len;
    int k;
    int j;
    int t;
    int r;
    if ($urandom_range(0, 9) == 0) begin
      for (k = 0; k < psc_pkg::CELL_COUNT; k++) perm[k] = k;
      for (k = psc_pkg::CELL_COUNT - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        t = perm[k];
        perm[k] = perm[j];
        perm[j] = t;
      end
      for (k = 0; k < psc_pkg::CELL_COUNT; k++) begin
        push_item(psc_pkg::CMD_KEY, alpha_char(psc_pkg::SYM_W'(perm[k])));
      end
      repeat ($urandom_range(1, 4)) push_item(psc_pkg::CMD_KEY, rand_symbol_char());
    end else begin
      len = $urandom_range(0, 10);
      for (k = 0; k < len; k++) begin
        r = $urandom_range(0, 9);
        if (r < 8) push_item(psc_pkg::CMD_KEY, rand_symbol_char());
        else if (r == 8) push_item(psc_pkg::CMD_KEY, psc_pkg::CHAR_W'($urandom_range(0, 255)));
        else push_item(psc_pkg::CMD_KEY, "a" + psc_pkg::CHAR_W'($urandom_range(0, 25)));
      end
    end
    // Occasionally leave the key open so messages run on a half-rebuilt square.
    if ($urandom_range(0, 7) != 0) begin
      push_item(psc_pkg::CMD_END_KEY, psc_pkg::CHAR_W'($urandom_range(0, 255)));
    end
  endtask

  // A message suited to the current mode, with blanks, junk and stray
  // commands sprinkled in.
  task automatic send_message();
    int len;
    int k;
    int r;
    len = $urandom_range(4, 24);
    for (k = 0; k < len; k++) begin
      r = $urandom_range(0, 19);
      if (enc_mode) begin
        if (r < 14) push_item(psc_pkg::CMD_MSG, rand_symbol_char());
        else if (r < 16) push_item(psc_pkg::CMD_MSG, rand_blank());
        else if (r < 18) push_item(psc_pkg::CMD_MSG, psc_pkg::CHAR_W'($urandom_range(0, 255)));
        else if (r == 18) push_item(CMD_UNUSED, psc_pkg::CHAR_W'($urandom_range(0, 255)));
        else push_item(psc_pkg::CMD_KEY, rand_symbol_char());
      end else begin
        if (r < 13) begin
          push_item(psc_pkg::CMD_MSG, psc_pkg::ASCII_0 +
                    psc_pkg::CHAR_W'($urandom_range(0, psc_pkg::GRID_SIDE - 1)));
          push_item(psc_pkg::CMD_MSG, psc_pkg::ASCII_0 +
                    psc_pkg::CHAR_W'($urandom_range(0, psc_pkg::GRID_SIDE - 1)));
        end else if (r < 15) begin
          push_item(psc_pkg::CMD_MSG, rand_blank());
        end else if (r < 17) begin
          push_item(psc_pkg::CMD_MSG, psc_pkg::ASCII_0 + psc_pkg::CHAR_W'($urandom_range(0, 9)));
        end else if (r == 17) begin
          push_item(psc_pkg::CMD_MSG, psc_pkg::CHAR_W'($urandom_range(0, 255)));
        end else if (r == 18) begin
          push_item($urandom_range(0, 1) ? CMD_UNUSED : psc_pkg::CMD_END_KEY,
                    psc_pkg::CHAR_W'($urandom_range(0, 255)));
        end else begin
          push_item(psc_pkg::CMD_KEY, rand_symbol_char());
        end
      end
    end
  endtask

  // Result channel backpressure: a long hold when asked for, otherwise a
  // style picked at random whenever the low six bits of rx_tick return to zero.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 1'b1;
      if (rx_tick[5:0] == 6'd0) rx_style <= rx_style_t'($urandom_range(0, 3));
      case (rx_style)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= (rx_tick[1:0] == 2'd0);
        default:   out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    cipher_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (expected_chars.size() == 0) begin
        $error("unexpected result: out_char %h out_last %b", out_char, out_last);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_char !== want.ch) begin
          $error("out_char: expected %h, got %h", want.ch, out_char);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %b, got %b", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake on any channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests; a mode change between rows goes through the
    // configuration port once the block is idle.
    foreach (probes[i]) begin
      if (probes[i].enc != enc_mode) write_mode(probes[i].enc);
      offer(probes[i].cmd, probes[i].ch, probes[i].typed, probes[i].n,
            probes[i].e0, probes[i].e1);
    end

    // Random phases: keys, messages and regular mode flips.
    useful_items = 0;
    phase = 0;
    while (requests_accepted < RANDOM_ITEMS) begin
      phase++;
      if (phase % 4 == 0) write_mode(!enc_mode);
      if (phase == 3) begin
        // Hold the result side off while requests keep coming, to back up
        // the block and stall its input.
        hold_asked <= hold_asked + 1;
        repeat (3) send_message();
      end
      if (phase == 7) drain_results();
      if ($urandom_range(0, 2) == 0) build_key();
      send_message();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0) begin
      $error("%0d expected results never arrived", expected_chars.size());
      fail_count++;
    end
    $display("Covered %0d requests (%0d random ones with an effect) and %0d checked results.",
             requests_accepted, useful_items, results_checked);
    $display("Built %0d squares (%0d keyed full); mode writes: %0d decrypt, %0d encrypt.",
             squares_built, full_keys, mode_writes[0], mode_writes[1]);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: polybius_square_cipher.f
rtl/psc_pkg.sv
rtl/psc_front.sv
rtl/psc_queue.sv
rtl/psc_back.sv
rtl/polybius_square_cipher.sv
test/testbench.sv
